// ----- hdl/scp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, codes and constants of the scope cycle profiler.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LOCATIONS   = 256;

  localparam int OP_W      = 2;
  localparam int LOC_IN_W  = 8;
  localparam int CYC_W     = 64;
  localparam int STATUS_W  = 3;
  localparam int SAMPLES_W = 32;
  localparam int DEPTH_W   = 6;
  localparam int UNREC_W   = 16;

  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int LOC_W = $clog2(LOCATIONS);
  localparam int LOC_IN_ENTRIES = 2 ** LOC_IN_W;

  localparam int STK_W   = LOC_W + CYC_W;
  localparam int STATS_W = SAMPLES_W + CYC_W;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_PUSHED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_START_UNREC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_END_UNREC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_END_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ        = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LOC_IN_W-1:0] location;
    logic [CYC_W-1:0]    cycles;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [LOC_IN_W-1:0]  location_res;
    logic [CYC_W-1:0]     elapsed;
    logic [SAMPLES_W-1:0] samples;
    logic [CYC_W-1:0]     cycle_sum;
    logic [DEPTH_W-1:0]   depth;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic                load;
    logic                push;
    logic                unrec_inc;
    logic                unrec_dec;
    logic                pop;
    logic                rd_top;
    logic                rd_loc;
    logic                close;
    logic                emit;
    logic [STATUS_W-1:0] code;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            unrec_nz;
  } dp_status_t;

  // location reduction table, built at elaboration
  typedef logic [LOC_W-1:0] loc_table_t [LOC_IN_ENTRIES];

  function automatic loc_table_t build_loc_table();
    loc_table_t t;
    for (int i = 0; i < LOC_IN_ENTRIES; i++) begin
      t[i] = LOC_W'(i % LOCATIONS);
    end
    return t;
  endfunction

  localparam loc_table_t LOC_MOD_TABLE = build_loc_table();

endpackage

// ----- hdl/scp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/scp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_ctrl
// Request sequencer: decodes one request and steps the datapath through it.
// ----------------------------------------------------------------------------
module scp_ctrl
  import scp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t dp_status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DECODE   = 2'd1;
  localparam logic [1:0] S_STK_WAIT = 2'd2;
  localparam logic [1:0] S_TBL_WAIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_PUSHED;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (dp_status.op)
          OP_START: begin
            cmd.emit = 1'b1;
            if (!dp_status.full) begin
              cmd.push = 1'b1;
              cmd.code = ST_PUSHED;
            end else begin
              cmd.unrec_inc = 1'b1;
              cmd.code      = ST_START_UNREC;
            end
          end
          OP_END: begin
            priority if (dp_status.unrec_nz) begin
              cmd.unrec_dec = 1'b1;
              cmd.emit      = 1'b1;
              cmd.code      = ST_END_UNREC;
            end else if (dp_status.empty) begin
              cmd.emit = 1'b1;
              cmd.code = ST_END_EMPTY;
            end else begin
              cmd.pop    = 1'b1;
              state_next = S_STK_WAIT;
            end
          end
          OP_READ: begin
            cmd.rd_loc = 1'b1;
            state_next = S_TBL_WAIT;
          end
          default: begin
            // unused op: no result
          end
        endcase
      end
      S_STK_WAIT: begin
        cmd.rd_top = 1'b1;
        state_next = S_TBL_WAIT;
      end
      S_TBL_WAIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
        if (dp_status.op == OP_END) begin
          cmd.close = 1'b1;
          cmd.code  = ST_CLOSED;
        end else begin
          cmd.code = ST_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/scp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_datapath
// Scope stack, statistics table, counters and result register.
// ----------------------------------------------------------------------------
module scp_datapath
  import scp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   item,
  input  ctrl_cmd_t  cmd,
  output dp_status_t dp_status,
  output logic       done,
  output result_t    result
);

  logic [OP_W-1:0]    op_q;
  logic [LOC_W-1:0]   loc_q;
  logic [CYC_W-1:0]   cyc_q;
  logic [LVL_W-1:0]   level;
  logic [LVL_W-1:0]   level_next;
  logic [LVL_W-1:0]   level_dec;
  logic [UNREC_W-1:0] unrec;
  logic [UNREC_W-1:0] unrec_next;
  logic [LOC_W-1:0]   top_q;
  logic [CYC_W-1:0]   elapsed_q;
  logic               rd_valid_q;
  logic [LOCATIONS-1:0] tbl_valid;

  logic [STK_W-1:0]   stk_rdata;
  logic [LOC_W-1:0]   stk_loc;
  logic [CYC_W-1:0]   stk_cyc;

  logic [LOC_W-1:0]   tbl_raddr;
  logic               tbl_re;
  logic [STATS_W-1:0] tbl_rdata;
  logic [SAMPLES_W-1:0] samples_cur;
  logic [CYC_W-1:0]   total_cur;
  logic [SAMPLES_W-1:0] samples_new;
  logic [CYC_W-1:0]   total_new;

  result_t result_next;

  assign level_dec = level - 1'b1;
  assign stk_loc   = stk_rdata[STK_W-1 -: LOC_W];
  assign stk_cyc   = stk_rdata[CYC_W-1:0];

  always_comb begin
    level_next = level;
    if (cmd.push) begin
      level_next = level + 1'b1;
    end else if (cmd.pop) begin
      level_next = level_dec;
    end
  end

  always_comb begin
    unrec_next = unrec;
    if (cmd.unrec_inc && (unrec != '1)) begin
      unrec_next = unrec + 1'b1;
    end else if (cmd.unrec_dec) begin
      unrec_next = unrec - 1'b1;
    end
  end

  assign dp_status.op       = op_q;
  assign dp_status.full     = (level == LVL_W'(STACK_DEPTH));
  assign dp_status.empty    = (level == '0);
  assign dp_status.unrec_nz = (unrec != '0);

  scp_ram #(
    .WIDTH (STK_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (level[SA_W-1:0]),
    .wdata ({loc_q, cyc_q}),
    .re    (cmd.pop),
    .raddr (level_dec[SA_W-1:0]),
    .rdata (stk_rdata)
  );

  assign tbl_re    = cmd.rd_top | cmd.rd_loc;
  assign tbl_raddr = cmd.rd_top ? stk_loc : loc_q;

  scp_ram #(
    .WIDTH (STATS_W),
    .DEPTH (LOCATIONS)
  ) u_stats (
    .clk   (clk),
    .we    (cmd.close),
    .waddr (top_q),
    .wdata ({samples_new, total_new}),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // entries never written since reset read as zero
  assign samples_cur = rd_valid_q ? tbl_rdata[STATS_W-1 -: SAMPLES_W] : '0;
  assign total_cur   = rd_valid_q ? tbl_rdata[CYC_W-1:0] : '0;
  assign samples_new = (samples_cur == '1) ? samples_cur : samples_cur + 1'b1;
  assign total_new   = total_cur + elapsed_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      unrec     <= '0;
      tbl_valid <= '0;
    end else begin
      level <= level_next;
      unrec <= unrec_next;
      if (cmd.close) begin
        tbl_valid[top_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= item.op;
      loc_q <= LOC_MOD_TABLE[item.location];
      cyc_q <= item.cycles;
    end
    if (cmd.rd_top) begin
      top_q     <= stk_loc;
      elapsed_q <= cyc_q - stk_cyc;
    end
    if (tbl_re) begin
      rd_valid_q <= tbl_valid[tbl_raddr];
    end
  end

  always_comb begin
    result_next        = '0;
    result_next.status = cmd.code;
    result_next.depth  = DEPTH_W'(level_next);
    unique case (cmd.code)
      ST_PUSHED: begin
        result_next.location_res = LOC_IN_W'(loc_q);
      end
      ST_CLOSED: begin
        result_next.location_res = LOC_IN_W'(top_q);
        result_next.elapsed      = elapsed_q;
        result_next.samples      = samples_new;
        result_next.cycle_sum    = total_new;
      end
      ST_READ: begin
        result_next.location_res = LOC_IN_W'(loc_q);
        result_next.samples      = samples_cur;
        result_next.cycle_sum    = total_cur;
      end
      default: begin
        // status-only results
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= result_next;
    end
  end

endmodule

// ----- hdl/scope_cycle_profiler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_cycle_profiler
// Per-location cycle statistics for nested scopes: start/end/read requests.
// ----------------------------------------------------------------------------
// Channel  Ports                  Handshake
// request  start, busy, item      taken at an edge with start high, busy low
// result   done, result           done high for one cycle, cannot be stalled
//
// One request at a time. Steps from accept to result strobe: a start, or an
// end without a pop, goes through decode alone; a read adds a table RAM read;
// a closing end adds a stack RAM read, then a table RAM read, then a table
// write. Op 3 keeps busy high for one cycle, no result. busy drops in the
// cycle the result shows, so a new request can be taken alongside it. Reset
// clears stack level, counters and table valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module scope_cycle_profiler
  import scp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  in_item_t item,
  output logic     done,
  output result_t  result
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  scp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .busy      (busy),
    .cmd       (cmd)
  );

  scp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .dp_status (dp_status),
    .done      (done),
    .result    (result)
  );

endmodule

// ----- hdl/scp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks of the scope cycle profiler, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker
  import scp_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input in_item_t item,
  input logic     done,
  input result_t  result
);

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_NONE) |=> ##1 !done)
    else $error("unused op produced a result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_READ))
    else $error("status code out of range");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_START_UNREC || result.status == ST_END_UNREC ||
              result.status == ST_END_EMPTY))
    |-> (result.location_res == '0 && result.elapsed == '0 &&
         result.samples == '0 && result.cycle_sum == '0))
    else $error("status-only result carries values");

endmodule

bind scope_cycle_profiler scp_checker u_scp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
